FILE: hdl/hqm_pkg.sv
// hqm_pkg: shared types, codes and helper functions for the NVMe host queue manager.
// No dependencies; used by the controller, the datapath, the top level and the checker.
package hqm_pkg;

  localparam int NUM_IDS     = 256;
  localparam int ID_W        = 8;
  localparam int GRP_W       = 16;
  localparam int NUM_GRP     = NUM_IDS / GRP_W;
  localparam int GSEL_W      = 4;
  localparam int BSEL_W      = 4;
  localparam int PTR_W       = 6;
  localparam int SIZE_W      = 7;
  localparam int ENTRY_SHIFT = 6;
  localparam int NRES_W      = 7;
  localparam int MAX_RESULTS = 64;

  // request modes
  localparam logic [1:0] MODE_SUBMIT = 2'd0;
  localparam logic [1:0] MODE_CPL    = 2'd1;
  localparam logic [1:0] MODE_CQ_ADV = 2'd2;
  localparam logic [1:0] MODE_ENTRY  = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_SQDB   = 3'd0;
  localparam logic [2:0] KIND_CQDB   = 3'd1;
  localparam logic [2:0] KIND_QUEUED = 3'd2;
  localparam logic [2:0] KIND_DONE   = 3'd3;
  localparam logic [2:0] KIND_ENTRY  = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;

  // entry opcodes
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_SQ_ENTRIES = 2'd0;
  localparam logic [1:0] CFG_CQ_ENTRIES = 2'd1;
  localparam logic [1:0] CFG_SQ_BASE    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUB_FIND,
    ST_SUB_EMIT,
    ST_CPL_RD,
    ST_CPL_EMIT,
    ST_CQ_EMIT,
    ST_ENT_SUB,
    ST_ENT_RD,
    ST_ENT_EMIT,
    ST_DRN_RD,
    ST_DRN_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic find;
    logic cpl_rd;
    logic addr_sub;
    logic ent_rd;
    logic drn_rd;
    logic emit_sub;
    logic emit_cpl;
    logic emit_cq;
    logic emit_ent;
    logic emit_drn;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic cpl_drain;
    logic drn_more;
  } sts_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] depth);
    logic [SIZE_W-1:0] r;
    if (v < SIZE_W'(2)) r = SIZE_W'(2);
    else if (v > depth) r = depth;
    else r = v;
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                               input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] sum;
    sum = {1'b0, p} + SIZE_W'(1);
    return (sum >= s) ? '0 : sum[PTR_W-1:0];
  endfunction

  function automatic logic ring_full(input logic [PTR_W-1:0] tail,
                                     input logic [PTR_W-1:0] head,
                                     input logic [SIZE_W-1:0] s);
    logic r;
    if ({1'b0, tail} < s - SIZE_W'(1)) r = (({1'b0, tail} + SIZE_W'(1)) == {1'b0, head});
    else r = (head == '0);
    return r;
  endfunction

endpackage

FILE: hdl/hqm_req_if.sv
// hqm_req_if: request channel of the queue manager (valid/ready plus request fields).
// Depends on nothing.
interface hqm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] request_tag;
  logic [63:0] first_block;
  logic [15:0] block_count;
  logic        is_read;
  logic [7:0]  cmd_ident;
  logic [5:0]  device_sq_head;
  logic [63:0] entry_address;

  modport source (output valid, mode, request_tag, first_block, block_count, is_read,
                  cmd_ident, device_sq_head, entry_address, input ready);
  modport sink (input valid, mode, request_tag, first_block, block_count, is_read,
                cmd_ident, device_sq_head, entry_address, output ready);
endinterface

FILE: hdl/hqm_rsp_if.sv
// hqm_rsp_if: result channel of the queue manager (valid/ready plus result fields).
// Depends on nothing.
interface hqm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [5:0]  pointer_value;
  logic [7:0]  assigned_id;
  logic [15:0] tag_out;
  logic [1:0]  opcode;
  logic [63:0] lba_out;
  logic [15:0] count_out;
  logic        last;

  modport source (output valid, kind, pointer_value, assigned_id, tag_out, opcode,
                  lba_out, count_out, last, input ready);
  modport sink (input valid, kind, pointer_value, assigned_id, tag_out, opcode,
                lba_out, count_out, last, output ready);
endinterface

FILE: hdl/hqm_ctrl.sv
// hqm_ctrl: sequencing state machine of the queue manager.
// Depends on hqm_pkg (state_e, cmd_t, sts_t, mode codes).
module hqm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic [1:0]    req_mode_i,
  output logic          req_ready_o,
  input  hqm_pkg::sts_t sts_i,
  output hqm_pkg::cmd_t cmd_o
);

  hqm_pkg::state_e state_q, state_d;
  logic accept;

  assign accept = req_valid_i && (state_q == hqm_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= hqm_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hqm_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          unique case (req_mode_i)
            hqm_pkg::MODE_SUBMIT: state_d = hqm_pkg::ST_SUB_FIND;
            hqm_pkg::MODE_CPL:    state_d = hqm_pkg::ST_CPL_RD;
            hqm_pkg::MODE_CQ_ADV: state_d = hqm_pkg::ST_CQ_EMIT;
            hqm_pkg::MODE_ENTRY:  state_d = hqm_pkg::ST_ENT_SUB;
            default:              state_d = hqm_pkg::ST_IDLE;
          endcase
        end
      end
      hqm_pkg::ST_SUB_FIND: state_d = hqm_pkg::ST_SUB_EMIT;
      hqm_pkg::ST_SUB_EMIT: if (sts_i.out_free) state_d = hqm_pkg::ST_IDLE;
      hqm_pkg::ST_CPL_RD:   state_d = hqm_pkg::ST_CPL_EMIT;
      hqm_pkg::ST_CPL_EMIT: begin
        if (sts_i.out_free)
          state_d = sts_i.cpl_drain ? hqm_pkg::ST_DRN_RD : hqm_pkg::ST_IDLE;
      end
      hqm_pkg::ST_CQ_EMIT:  if (sts_i.out_free) state_d = hqm_pkg::ST_IDLE;
      hqm_pkg::ST_ENT_SUB:  state_d = hqm_pkg::ST_ENT_RD;
      hqm_pkg::ST_ENT_RD:   state_d = hqm_pkg::ST_ENT_EMIT;
      hqm_pkg::ST_ENT_EMIT: if (sts_i.out_free) state_d = hqm_pkg::ST_IDLE;
      hqm_pkg::ST_DRN_RD:   state_d = hqm_pkg::ST_DRN_EMIT;
      hqm_pkg::ST_DRN_EMIT: begin
        if (sts_i.out_free)
          state_d = sts_i.drn_more ? hqm_pkg::ST_DRN_RD : hqm_pkg::ST_IDLE;
      end
      default: state_d = hqm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      hqm_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.capture = accept;
      end
      hqm_pkg::ST_SUB_FIND: cmd_o.find = 1'b1;
      hqm_pkg::ST_SUB_EMIT: cmd_o.emit_sub = sts_i.out_free;
      hqm_pkg::ST_CPL_RD:   cmd_o.cpl_rd = 1'b1;
      hqm_pkg::ST_CPL_EMIT: cmd_o.emit_cpl = sts_i.out_free;
      hqm_pkg::ST_CQ_EMIT:  cmd_o.emit_cq = sts_i.out_free;
      hqm_pkg::ST_ENT_SUB:  cmd_o.addr_sub = 1'b1;
      hqm_pkg::ST_ENT_RD:   cmd_o.ent_rd = 1'b1;
      hqm_pkg::ST_ENT_EMIT: cmd_o.emit_ent = sts_i.out_free;
      hqm_pkg::ST_DRN_RD: begin
        cmd_o.drn_rd = 1'b1;
        cmd_o.find = 1'b1;
      end
      hqm_pkg::ST_DRN_EMIT: cmd_o.emit_drn = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: hdl/hqm_dp.sv
// hqm_dp: datapath of the queue manager: ring pointers, id map, rings, wait FIFO, result register.
// Depends on hqm_pkg (cmd_t, sts_t, codes, ring helper functions).
module hqm_dp #(
  parameter int SQ_DEPTH   = 64,
  parameter int CQ_DEPTH   = 64,
  parameter int WAIT_DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hqm_pkg::cmd_t cmd_i,
  output hqm_pkg::sts_t sts_o,
  // configuration
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [63:0]   cfg_wdata_i,
  // request fields
  input  logic [15:0]   req_tag_i,
  input  logic [63:0]   req_lba_i,
  input  logic [15:0]   req_cnt_i,
  input  logic          req_rd_i,
  input  logic [7:0]    req_cid_i,
  input  logic [5:0]    req_dhead_i,
  input  logic [63:0]   req_addr_i,
  // result register
  input  logic          rsp_ready_i,
  output logic          rsp_valid_o,
  output logic [2:0]    rsp_kind_o,
  output logic [5:0]    rsp_ptr_o,
  output logic [7:0]    rsp_id_o,
  output logic [15:0]   rsp_tag_o,
  output logic [1:0]    rsp_op_o,
  output logic [63:0]   rsp_lba_o,
  output logic [15:0]   rsp_cnt_o,
  output logic          rsp_last_o
);

  localparam int SQ_AW  = $clog2(SQ_DEPTH);
  localparam int WA     = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int WCW    = $clog2(WAIT_DEPTH + 1);
  localparam int WSW    = WCW + 1;
  localparam int SLOT_W = 8 + 1 + 16 + 64;
  localparam int WAIT_W = 1 + 16 + 16 + 64;
  localparam int SW     = hqm_pkg::SIZE_W;
  localparam int PW     = hqm_pkg::PTR_W;

  // configuration
  logic [SW-1:0] sq_ent_q, cq_ent_q;
  logic [63:0]   sq_base_q;
  logic [SW-1:0] sq_s, cq_s;

  // captured request
  logic [15:0] tag_q, cnt_q;
  logic [63:0] lba_q, addr_q;
  logic        rd_q;
  logic [7:0]  cid_q;
  logic [5:0]  dhead_q;

  // queue state
  logic [PW-1:0]                  tail_q, head_q, cqh_q;
  logic [SQ_DEPTH-1:0]            slot_vld_q;
  logic [hqm_pkg::NUM_IDS-1:0]    id_busy_q;
  logic [hqm_pkg::ID_W:0]         used_q;
  logic [WA-1:0]                  rptr_q;
  logic [WCW-1:0]                 wcnt_q;
  logic [hqm_pkg::NRES_W-1:0]     nres_q;
  logic [hqm_pkg::NUM_GRP-1:0]    grp_q;

  // memories and their read registers
  logic [SLOT_W-1:0] slot_mem [SQ_DEPTH];
  logic [15:0]       tag_mem  [hqm_pkg::NUM_IDS];
  logic [WAIT_W-1:0] wait_mem [WAIT_DEPTH];
  logic [SLOT_W-1:0] slot_rd_q;
  logic [15:0]       tag_rd_q;
  logic [WAIT_W-1:0] wait_rd_q;
  logic [63:0]       diff_q;
  logic              ent_ok_q;

  // result register
  logic        ov_q;
  logic [2:0]  okind_q;
  logic [5:0]  optr_q;
  logic [7:0]  oid_q;
  logic [15:0] otag_q, ocnt_q;
  logic [1:0]  oop_q;
  logic [63:0] olba_q;
  logic        olast_q;

  logic out_free;
  assign out_free = !ov_q || rsp_ready_i;

  assign sq_s = hqm_pkg::clamp_size(sq_ent_q, SW'(SQ_DEPTH));
  assign cq_s = hqm_pkg::clamp_size(cq_ent_q, SW'(CQ_DEPTH));

  // lowest free id: group flags registered in the find step, then two 16-way encoders
  logic [hqm_pkg::NUM_GRP-1:0] grp_d;
  logic [hqm_pkg::GSEL_W-1:0]  gsel;
  logic [hqm_pkg::BSEL_W-1:0]  bsel;
  logic [hqm_pkg::GRP_W-1:0]   gbits;
  logic [hqm_pkg::ID_W-1:0]    low_id;
  logic [hqm_pkg::NUM_IDS-1:0] id_free;

  assign id_free = ~id_busy_q;

  always_comb begin
    for (int g = 0; g < hqm_pkg::NUM_GRP; g++)
      grp_d[g] = |id_free[g*hqm_pkg::GRP_W +: hqm_pkg::GRP_W];
  end

  always_comb begin
    logic gf, bf;
    gf = 1'b0;
    bf = 1'b0;
    gsel = '0;
    bsel = '0;
    for (int g = 0; g < hqm_pkg::NUM_GRP; g++) begin
      if (!gf && grp_q[g]) begin
        gsel = hqm_pkg::GSEL_W'(g);
        gf = 1'b1;
      end
    end
    gbits = id_free[gsel*hqm_pkg::GRP_W +: hqm_pkg::GRP_W];
    for (int b = 0; b < hqm_pkg::GRP_W; b++) begin
      if (!bf && gbits[b]) begin
        bsel = hqm_pkg::BSEL_W'(b);
        bf = 1'b1;
      end
    end
  end
  assign low_id = {gsel, bsel};

  // decisions
  logic [PW-1:0] new_tail, new_head, cq_next;
  logic          sub_issue, sub_queue, cid_busy, ids_left;
  logic          drn_more, cpl_drain;
  logic [WSW-1:0] wsum;
  logic [WA-1:0]  wptr, rnext;
  logic [WA:0]    rinc;

  assign new_tail  = hqm_pkg::ptr_inc(tail_q, sq_s);
  assign cq_next   = hqm_pkg::ptr_inc(cqh_q, cq_s);
  assign ids_left  = used_q < (hqm_pkg::ID_W + 1)'(hqm_pkg::NUM_IDS);
  assign sub_issue = !hqm_pkg::ring_full(tail_q, head_q, sq_s) && ids_left;
  assign sub_queue = !sub_issue && (wcnt_q < WCW'(WAIT_DEPTH));
  assign cid_busy  = id_busy_q[cid_q];
  assign new_head  = ({1'b0, dhead_q} < sq_s) ? dhead_q : head_q;
  assign cpl_drain = cid_busy && (wcnt_q != '0) &&
                     !hqm_pkg::ring_full(tail_q, new_head, sq_s);
  assign drn_more  = (wcnt_q > WCW'(1)) && !hqm_pkg::ring_full(new_tail, head_q, sq_s) &&
                     ((used_q + (hqm_pkg::ID_W + 1)'(1)) <
                      (hqm_pkg::ID_W + 1)'(hqm_pkg::NUM_IDS)) &&
                     ((nres_q + hqm_pkg::NRES_W'(1)) <
                      hqm_pkg::NRES_W'(hqm_pkg::MAX_RESULTS));

  assign wsum  = WSW'(rptr_q) + WSW'(wcnt_q);
  assign wptr  = (wsum >= WSW'(WAIT_DEPTH)) ? WA'(wsum - WSW'(WAIT_DEPTH)) : WA'(wsum);
  assign rinc  = {1'b0, rptr_q} + (WA + 1)'(1);
  assign rnext = (rinc >= (WA + 1)'(WAIT_DEPTH)) ? '0 : rinc[WA-1:0];

  assign sts_o.out_free  = out_free;
  assign sts_o.cpl_drain = cpl_drain;
  assign sts_o.drn_more  = drn_more;

  // issue into the ring: fresh submit or a drained waiting request
  logic        iss_en, wq_en;
  logic [15:0] iss_tag, iss_cnt;
  logic [63:0] iss_lba;
  logic        iss_rd;

  assign iss_en  = (cmd_i.emit_sub && sub_issue) || cmd_i.emit_drn;
  assign wq_en   = cmd_i.emit_sub && sub_queue;
  assign iss_tag = cmd_i.emit_drn ? wait_rd_q[79:64]   : tag_q;
  assign iss_cnt = cmd_i.emit_drn ? wait_rd_q[95:80]   : cnt_q;
  assign iss_lba = cmd_i.emit_drn ? wait_rd_q[63:0]    : lba_q;
  assign iss_rd  = cmd_i.emit_drn ? wait_rd_q[96]      : rd_q;

  // entry read range check
  logic ent_range;
  logic [SQ_AW-1:0] ent_idx;
  assign ent_idx   = diff_q[hqm_pkg::ENTRY_SHIFT +: SQ_AW];
  assign ent_range = (diff_q[63:hqm_pkg::ENTRY_SHIFT+SW] == '0) &&
                     (diff_q[hqm_pkg::ENTRY_SHIFT +: SW] < sq_s);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_ent_q   <= SW'(64);
      cq_ent_q   <= SW'(64);
      sq_base_q  <= '0;
      tail_q     <= '0;
      head_q     <= '0;
      cqh_q      <= '0;
      slot_vld_q <= '0;
      id_busy_q  <= '0;
      used_q     <= '0;
      rptr_q     <= '0;
      wcnt_q     <= '0;
      nres_q     <= '0;
      ov_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hqm_pkg::CFG_SQ_ENTRIES: sq_ent_q <= cfg_wdata_i[SW-1:0];
          hqm_pkg::CFG_CQ_ENTRIES: cq_ent_q <= cfg_wdata_i[SW-1:0];
          hqm_pkg::CFG_SQ_BASE:    sq_base_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (iss_en) begin
        tail_q <= new_tail;
        slot_vld_q[tail_q[SQ_AW-1:0]] <= 1'b1;
        id_busy_q[low_id] <= 1'b1;
        used_q <= used_q + (hqm_pkg::ID_W + 1)'(1);
      end
      if (wq_en) wcnt_q <= wcnt_q + WCW'(1);
      if (cmd_i.emit_drn) begin
        rptr_q <= rnext;
        wcnt_q <= wcnt_q - WCW'(1);
        nres_q <= nres_q + hqm_pkg::NRES_W'(1);
      end
      if (cmd_i.emit_cpl && cid_busy) begin
        id_busy_q[cid_q] <= 1'b0;
        used_q <= used_q - (hqm_pkg::ID_W + 1)'(1);
        head_q <= new_head;
        nres_q <= hqm_pkg::NRES_W'(1);
      end
      if (cmd_i.emit_cq) cqh_q <= cq_next;
      if (cmd_i.emit_sub || cmd_i.emit_cpl || cmd_i.emit_cq ||
          cmd_i.emit_ent || cmd_i.emit_drn) ov_q <= 1'b1;
      else if (rsp_ready_i) ov_q <= 1'b0;
    end
  end

  // payload registers and memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tag_q   <= req_tag_i;
      lba_q   <= req_lba_i;
      cnt_q   <= req_cnt_i;
      rd_q    <= req_rd_i;
      cid_q   <= req_cid_i;
      dhead_q <= req_dhead_i;
      addr_q  <= req_addr_i;
    end
    if (cmd_i.find) grp_q <= grp_d;
    if (cmd_i.addr_sub) diff_q <= addr_q - sq_base_q;
    if (cmd_i.ent_rd) begin
      slot_rd_q <= slot_mem[ent_idx];
      ent_ok_q  <= ent_range && slot_vld_q[ent_idx];
    end
    if (cmd_i.cpl_rd) tag_rd_q <= tag_mem[cid_q];
    if (cmd_i.drn_rd) wait_rd_q <= wait_mem[rptr_q];
    if (iss_en) begin
      slot_mem[tail_q[SQ_AW-1:0]] <= {low_id, iss_rd, iss_cnt, iss_lba};
      tag_mem[low_id] <= iss_tag;
    end
    if (wq_en) wait_mem[wptr] <= {rd_q, cnt_q, tag_q, lba_q};
  end

  // result register load
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sub || cmd_i.emit_cpl || cmd_i.emit_cq ||
        cmd_i.emit_ent || cmd_i.emit_drn) begin
      okind_q <= hqm_pkg::KIND_ERROR;
      optr_q  <= '0;
      oid_q   <= '0;
      otag_q  <= '0;
      oop_q   <= hqm_pkg::OP_NONE;
      olba_q  <= '0;
      ocnt_q  <= '0;
      olast_q <= 1'b1;
      if (cmd_i.emit_sub) begin
        otag_q <= tag_q;
        if (sub_issue) begin
          okind_q <= hqm_pkg::KIND_SQDB;
          optr_q  <= new_tail;
          oid_q   <= low_id;
        end else if (sub_queue) begin
          okind_q <= hqm_pkg::KIND_QUEUED;
        end
      end
      if (cmd_i.emit_drn) begin
        okind_q <= hqm_pkg::KIND_SQDB;
        optr_q  <= new_tail;
        oid_q   <= low_id;
        otag_q  <= iss_tag;
        olast_q <= !drn_more;
      end
      if (cmd_i.emit_cpl) begin
        oid_q <= cid_q;
        if (cid_busy) begin
          okind_q <= hqm_pkg::KIND_DONE;
          otag_q  <= tag_rd_q;
          olast_q <= !cpl_drain;
        end
      end
      if (cmd_i.emit_cq) begin
        okind_q <= hqm_pkg::KIND_CQDB;
        optr_q  <= cq_next;
      end
      if (cmd_i.emit_ent && ent_ok_q) begin
        okind_q <= hqm_pkg::KIND_ENTRY;
        oid_q   <= slot_rd_q[88:81];
        oop_q   <= slot_rd_q[80] ? hqm_pkg::OP_READ : hqm_pkg::OP_WRITE;
        ocnt_q  <= slot_rd_q[79:64];
        olba_q  <= slot_rd_q[63:0];
      end
    end
  end

  assign rsp_valid_o = ov_q;
  assign rsp_kind_o  = okind_q;
  assign rsp_ptr_o   = optr_q;
  assign rsp_id_o    = oid_q;
  assign rsp_tag_o   = otag_q;
  assign rsp_op_o    = oop_q;
  assign rsp_lba_o   = olba_q;
  assign rsp_cnt_o   = ocnt_q;
  assign rsp_last_o  = olast_q;

endmodule

FILE: hdl/nvme_host_queue_manager_core.sv
// Steps, accept to result valid: submit runs the id search, then emits; completion reads the
//   tag, emits, then reads and emits each drained request; cq advance emits at once; entry
//   read subtracts the base, reads the ring slot, then emits. One request in flight: a new
//   request is taken only once the last result of the one before has loaded. A result held
//   by the receiver stalls the emit step until it is taken.
// Reset (rst_ni low, async): pointers zero, all ids free, no ring slot valid, wait FIFO
//   empty, ring sizes 64, base address 0. No clearing pass; ready right after reset.
module nvme_host_queue_manager_core #(
  parameter int SQ_DEPTH   = 64,
  parameter int CQ_DEPTH   = 64,
  parameter int WAIT_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hqm_req_if.sink     req_i,
  hqm_rsp_if.source   rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  hqm_pkg::cmd_t cmd;
  hqm_pkg::sts_t sts;

  // controller: walks each request through find / subtract / read / emit steps
  hqm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_mode_i  (req_i.mode),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: queue state, memories and the result register
  hqm_dp #(
    .SQ_DEPTH   (SQ_DEPTH),
    .CQ_DEPTH   (CQ_DEPTH),
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_tag_i   (req_i.request_tag),
    .req_lba_i   (req_i.first_block),
    .req_cnt_i   (req_i.block_count),
    .req_rd_i    (req_i.is_read),
    .req_cid_i   (req_i.cmd_ident),
    .req_dhead_i (req_i.device_sq_head),
    .req_addr_i  (req_i.entry_address),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_kind_o  (rsp_o.kind),
    .rsp_ptr_o   (rsp_o.pointer_value),
    .rsp_id_o    (rsp_o.assigned_id),
    .rsp_tag_o   (rsp_o.tag_out),
    .rsp_op_o    (rsp_o.opcode),
    .rsp_lba_o   (rsp_o.lba_out),
    .rsp_cnt_o   (rsp_o.count_out),
    .rsp_last_o  (rsp_o.last)
  );

endmodule

FILE: hdl/hqm_checker.sv
// hqm_checker: port-level assertions for the queue manager, bound to the top level.
// Depends on hqm_pkg (kind and opcode codes).
module hqm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  rsp_kind_i,
  input logic [1:0]  rsp_op_i,
  input logic [63:0] rsp_lba_i,
  input logic        rsp_last_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_kind_i))
    else $error("result dropped or changed while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_kind_i <= hqm_pkg::KIND_ERROR)
    else $error("unknown result kind");

  a_entry_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_kind_i != hqm_pkg::KIND_ENTRY |->
      rsp_op_i == hqm_pkg::OP_NONE && rsp_lba_i == '0)
    else $error("entry fields set on a non-entry result");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in progress");

  a_queued_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_kind_i == hqm_pkg::KIND_QUEUED |-> rsp_last_i)
    else $error("queued result not marked last");

endmodule

bind nvme_host_queue_manager_core hqm_checker u_hqm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_kind_i  (rsp_o.kind),
  .rsp_op_i    (rsp_o.opcode),
  .rsp_lba_i   (rsp_o.lba_out),
  .rsp_last_i  (rsp_o.last)
);
